// ===== src/opu_pkg.sv =====
// Shared types, constants and helpers of the optimizer parameter update block.
package opu_pkg;

  localparam int PARAM_COUNT = 4096;
  localparam int IDX_W       = 12;

  typedef enum logic [1:0] {
    MODE_SGD  = 2'd0,
    MODE_MOM  = 2'd1,
    MODE_ADAM = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_LR       = 3'd1,
    REG_MOM_BETA = 3'd2,
    REG_BETA1    = 3'd3,
    REG_BETA2    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    mode_t       mode;
    logic [23:0] lr;
    logic [23:0] mom_beta;
    logic [23:0] beta1;
    logic [23:0] beta2;
  } cfg_t;

  // Item sideband: index, carried value (final result or x), rule, moment sign
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [31:0]      val;
    mode_t            mode;
    logic             neg;
  } side_t;

  // Moment stage -> normalize stage
  typedef struct packed {
    side_t       side;
    logic [31:0] am;
    logic [31:0] v;
    logic [24:0] c1;
    logic [24:0] c2;
    logic        ovf1;
  } mom_t;

  // Normalize stage -> square root stage
  typedef struct packed {
    side_t       side;
    logic [30:0] mh;
    logic [63:0] arg;
    logic        big;
  } nrm_t;

  // Square root stage -> step stage
  typedef struct packed {
    side_t       side;
    logic [30:0] mh;
    logic [40:0] den;
    logic        ovf2;
  } sq_t;

  function automatic logic [31:0] sat32(input logic [39:0] x);
    logic [31:0] r;
    if (!x[39] && (|x[38:31]))     r = 32'h7FFF_FFFF;
    else if (x[39] && !(&x[38:31])) r = 32'h8000_0000;
    else                            r = x[31:0];
    return r;
  endfunction

endpackage

// ===== src/opu_state.sv =====
// Moment stores, beta powers, store clearing and the moment update stages.
module opu_state (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          acc,
  input  opu_pkg::cfg_t                 cfg,
  input  logic [opu_pkg::IDX_W-1:0]     in_idx,
  input  logic [31:0]                   in_x,
  input  logic [31:0]                   in_g,
  input  logic                          in_last,
  output logic                          in_ok,
  output logic                          out_valid,
  output opu_pkg::mom_t                 out_data
);

  logic [31:0] m_mem [opu_pkg::PARAM_COUNT];
  logic [31:0] v_mem [opu_pkg::PARAM_COUNT];
  logic [31:0] m_rd_r, v_rd_r;

  logic [opu_pkg::IDX_W:0] clr_cnt_r;
  logic                    clearing;

  logic [24:0] bp1_r, bp2_r;
  logic [48:0] p1_full, p2_full;
  logic [24:0] c1_c, c2_c;

  logic [5:1] v_r;

  // stage 1
  logic [opu_pkg::IDX_W-1:0] idx1_r;
  logic [31:0]               x1_r, g1_r;
  opu_pkg::mode_t            mode1_r;
  logic [24:0]               c1_1_r, c2_1_r;
  // stage 2
  logic [opu_pkg::IDX_W-1:0] idx2_r;
  logic [31:0]               x2_r, g2_r;
  opu_pkg::mode_t            mode2_r;
  logic [24:0]               c1_2_r, c2_2_r;
  logic signed [56:0]        pm2_r, pl2_r;
  logic signed [57:0]        pg2_r;
  logic [63:0]               sq2_r;
  logic [55:0]               pv2_r;
  // stage 3
  logic [opu_pkg::IDX_W-1:0] idx3_r;
  logic [31:0]               val3_r, m3_r, pvs3_r;
  opu_pkg::mode_t            mode3_r;
  logic [24:0]               c1_3_r, c2_3_r;
  logic [44:0]               ph3_r;
  logic [43:0]               plo3_r;
  // stage 4
  logic [opu_pkg::IDX_W-1:0] idx4_r;
  logic [31:0]               val4_r, m4_r, v4_r;
  opu_pkg::mode_t            mode4_r;
  logic [24:0]               c1_4_r, c2_4_r;
  logic signed [56:0]        pmo4_r;
  // stage 5
  opu_pkg::mom_t             s5_r;

  // stage 1 combinational
  logic [23:0]        bsel;
  logic [24:0]        cb1, cb2;
  logic [31:0]        ag;
  logic signed [56:0] pm_c, pl_c;
  logic signed [57:0] pg_c;
  // stage 2 combinational
  logic [39:0]        mq_x, gq_x, g_x, x2_x, pl_x;
  logic [31:0]        m_new, r_sgd;
  logic [38:0]        g2;
  // stage 3 combinational
  logic [63:0]        gc;
  logic [39:0]        vsum;
  logic [31:0]        v_new;
  logic signed [56:0] pmo_c;
  // stage 4 combinational
  logic [31:0]        r_mom, am;

  logic                      m_we, v_we;
  logic [opu_pkg::IDX_W-1:0] m_wa, v_wa;
  logic [31:0]               m_wd, v_wd;
  logic                      hz, rmw_mode;

  assign clearing = !clr_cnt_r[opu_pkg::IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // Same index still between read and write-back holds off the next item
  assign rmw_mode = (cfg.mode == opu_pkg::MODE_MOM) || (cfg.mode == opu_pkg::MODE_ADAM);
  assign hz = rmw_mode && ((v_r[1] && idx1_r == in_idx) || (v_r[2] && idx2_r == in_idx) ||
                           (v_r[3] && idx3_r == in_idx));
  assign in_ok = !clearing && !hz;

  // Beta powers
  assign p1_full = bp1_r * cfg.beta1;
  assign p2_full = bp2_r * cfg.beta2;
  assign c1_c    = 25'h100_0000 - p1_full[48:24];
  assign c2_c    = 25'h100_0000 - p2_full[48:24];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp1_r <= 25'h100_0000;
      bp2_r <= 25'h100_0000;
    end else if (acc && in_last && cfg.mode == opu_pkg::MODE_ADAM) begin
      bp1_r <= p1_full[48:24];
      bp2_r <= p2_full[48:24];
    end
  end

  // Stores
  assign m_we = clearing || (en && v_r[2] &&
                (mode2_r == opu_pkg::MODE_MOM || mode2_r == opu_pkg::MODE_ADAM));
  assign m_wa = clearing ? clr_cnt_r[opu_pkg::IDX_W-1:0] : idx2_r;
  assign m_wd = clearing ? 32'd0 : m_new;
  assign v_we = clearing || (en && v_r[3] && mode3_r == opu_pkg::MODE_ADAM);
  assign v_wa = clearing ? clr_cnt_r[opu_pkg::IDX_W-1:0] : idx3_r;
  assign v_wd = clearing ? 32'd0 : v_new;

  always_ff @(posedge clk) begin
    if (m_we) m_mem[m_wa] <= m_wd;
    if (en) m_rd_r <= m_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (v_we) v_mem[v_wa] <= v_wd;
    if (en) v_rd_r <= v_mem[in_idx];
  end

  // Stage 1: products
  assign bsel = (mode1_r == opu_pkg::MODE_MOM) ? cfg.mom_beta : cfg.beta1;
  assign cb1  = 25'h100_0000 - {1'b0, cfg.beta1};
  assign cb2  = 25'h100_0000 - {1'b0, cfg.beta2};
  assign ag   = g1_r[31] ? (~g1_r + 32'd1) : g1_r;
  assign pm_c = $signed(m_rd_r) * $signed({1'b0, bsel});
  assign pg_c = $signed(g1_r) * $signed({1'b0, cb1});
  assign pl_c = $signed(g1_r) * $signed({1'b0, cfg.lr});

  // Stage 2: new first moment, plain result
  assign mq_x  = {{7{pm2_r[56]}}, pm2_r[56:24]};
  assign gq_x  = {{6{pg2_r[57]}}, pg2_r[57:24]};
  assign g_x   = {{8{g2_r[31]}}, g2_r};
  assign x2_x  = {{8{x2_r[31]}}, x2_r};
  assign pl_x  = {{7{pl2_r[56]}}, pl2_r[56:24]};
  assign m_new = (mode2_r == opu_pkg::MODE_MOM) ? opu_pkg::sat32(mq_x + g_x)
                                                 : opu_pkg::sat32(mq_x + gq_x);
  assign r_sgd = opu_pkg::sat32(x2_x - pl_x);
  assign g2    = sq2_r[62:24];

  // Stage 3: new second moment
  assign gc    = {ph3_r, 19'd0} + {20'd0, plo3_r};
  assign vsum  = {8'd0, pvs3_r} + gc[63:24];
  assign v_new = (|vsum[39:32]) ? 32'hFFFF_FFFF : vsum[31:0];
  assign pmo_c = $signed(m3_r) * $signed({1'b0, cfg.lr});

  // Stage 4: momentum result, moment magnitude
  assign r_mom = opu_pkg::sat32({{8{val4_r[31]}}, val4_r} -
                                {{7{pmo4_r[56]}}, pmo4_r[56:24]});
  assign am    = m4_r[31] ? (~m4_r + 32'd1) : m4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[4:1], acc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r  <= in_idx;
      x1_r    <= in_x;
      g1_r    <= in_g;
      mode1_r <= cfg.mode;
      c1_1_r  <= c1_c;
      c2_1_r  <= c2_c;

      idx2_r  <= idx1_r;
      x2_r    <= x1_r;
      g2_r    <= g1_r;
      mode2_r <= mode1_r;
      c1_2_r  <= c1_1_r;
      c2_2_r  <= c2_1_r;
      pm2_r   <= pm_c;
      pg2_r   <= pg_c;
      pl2_r   <= pl_c;
      sq2_r   <= ag * ag;
      pv2_r   <= v_rd_r * cfg.beta2;

      idx3_r  <= idx2_r;
      val3_r  <= (mode2_r == opu_pkg::MODE_SGD) ? r_sgd : x2_r;
      m3_r    <= m_new;
      pvs3_r  <= pv2_r[55:24];
      mode3_r <= mode2_r;
      c1_3_r  <= c1_2_r;
      c2_3_r  <= c2_2_r;
      ph3_r   <= g2[38:19] * cb2;
      plo3_r  <= g2[18:0] * cb2;

      idx4_r  <= idx3_r;
      val4_r  <= val3_r;
      m4_r    <= m3_r;
      v4_r    <= v_new;
      mode4_r <= mode3_r;
      c1_4_r  <= c1_3_r;
      c2_4_r  <= c2_3_r;
      pmo4_r  <= pmo_c;

      s5_r.side.idx  <= idx4_r;
      s5_r.side.val  <= (mode4_r == opu_pkg::MODE_MOM) ? r_mom : val4_r;
      s5_r.side.mode <= mode4_r;
      s5_r.side.neg  <= m4_r[31];
      s5_r.am        <= am;
      s5_r.v         <= v4_r;
      s5_r.c1        <= c1_4_r;
      s5_r.c2        <= c2_4_r;
      s5_r.ovf1      <= (am >= {c1_4_r, 7'd0});
    end
  end

  assign out_valid = v_r[5];
  assign out_data  = s5_r;

endmodule

// ===== src/opu_norm.sv =====
// Bias correction: two pipelined restoring dividers, one quotient bit per stage.
module opu_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  opu_pkg::mom_t in_data,
  output logic          out_valid,
  output opu_pkg::nrm_t out_data
);

  localparam int NSTEP = 56;
  localparam int ASTEP = 31;

  typedef struct packed {
    opu_pkg::side_t side;
    logic [24:0]    ra;
    logic [30:0]    wa;
    logic [24:0]    rb;
    logic [55:0]    wb;
    logic [24:0]    d1;
    logic [24:0]    d2;
    logic           ovf1;
  } dstg_t;

  function automatic dstg_t div_step(input dstg_t s, input logic do_a);
    dstg_t       o;
    logic [25:0] ta, tb;
    o  = s;
    ta = {s.ra, s.wa[30]};
    tb = {s.rb, s.wb[55]};
    if (do_a) begin
      if (ta >= {1'b0, s.d1}) begin
        o.ra = 25'(ta - {1'b0, s.d1});
        o.wa = {s.wa[29:0], 1'b1};
      end else begin
        o.ra = ta[24:0];
        o.wa = {s.wa[29:0], 1'b0};
      end
    end
    if (tb >= {1'b0, s.d2}) begin
      o.rb = 25'(tb - {1'b0, s.d2});
      o.wb = {s.wb[54:0], 1'b1};
    end else begin
      o.rb = tb[24:0];
      o.wb = {s.wb[54:0], 1'b0};
    end
    return o;
  endfunction

  dstg_t              init_c;
  dstg_t              st_r [1:NSTEP];
  logic [NSTEP:1]     vld_r;
  opu_pkg::nrm_t      out_r;
  logic               out_v_r;
  logic [55:0]        vh;
  logic               big;

  assign init_c.side = in_data.side;
  assign init_c.ra   = in_data.am[31:7];
  assign init_c.wa   = {in_data.am[6:0], 24'd0};
  assign init_c.rb   = '0;
  assign init_c.wb   = {in_data.v, 24'd0};
  assign init_c.d1   = in_data.c1;
  assign init_c.d2   = in_data.c2;
  assign init_c.ovf1 = in_data.ovf1;

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    dstg_t src;
    if (k == 1) begin : g_first
      assign src = init_c;
    end else begin : g_next
      assign src = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) st_r[k] <= div_step(src, k <= ASTEP);
    end
  end

  assign vh  = st_r[NSTEP].wb;
  assign big = |vh[55:40];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[NSTEP-1:1], in_valid};
      out_v_r <= vld_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.side <= st_r[NSTEP].side;
      out_r.mh   <= st_r[NSTEP].ovf1 ? 31'h7FFF_FFFF : st_r[NSTEP].wa;
      out_r.arg  <= big ? {vh, 8'd0} : {vh[39:0], 24'd0};
      out_r.big  <= big;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== src/opu_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
module opu_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  opu_pkg::nrm_t in_data,
  output logic          out_valid,
  output opu_pkg::sq_t  out_data
);

  localparam int NSTEP = 32;

  typedef struct packed {
    opu_pkg::side_t side;
    logic [30:0]    mh;
    logic [63:0]    arg;
    logic [33:0]    rem;
    logic [31:0]    root;
    logic           big;
  } sstg_t;

  function automatic sstg_t sqrt_step(input sstg_t s);
    sstg_t       o;
    logic [35:0] t, trial;
    o     = s;
    t     = {s.rem, s.arg[63:62]};
    trial = {2'd0, s.root, 2'b01};
    o.arg = {s.arg[61:0], 2'b00};
    if (t >= trial) begin
      o.rem  = 34'(t - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = t[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  sstg_t          init_c;
  sstg_t          st_r [1:NSTEP];
  logic [NSTEP:1] vld_r;
  opu_pkg::sq_t   out_r;
  logic           out_v_r;
  logic [39:0]    s;
  logic [40:0]    den;

  assign init_c.side = in_data.side;
  assign init_c.mh   = in_data.mh;
  assign init_c.arg  = in_data.arg;
  assign init_c.rem  = '0;
  assign init_c.root = '0;
  assign init_c.big  = in_data.big;

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    sstg_t src;
    if (k == 1) begin : g_first
      assign src = init_c;
    end else begin : g_next
      assign src = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) st_r[k] <= sqrt_step(src);
    end
  end

  // Large arguments were taken with 16 fewer fraction bits
  assign s   = st_r[NSTEP].big ? {st_r[NSTEP].root, 8'd0} : {8'd0, st_r[NSTEP].root};
  assign den = {1'b0, s} + 41'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[NSTEP-1:1], in_valid};
      out_v_r <= vld_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.side <= st_r[NSTEP].side;
      out_r.mh   <= st_r[NSTEP].mh;
      out_r.den  <= den;
      out_r.ovf2 <= ({17'd0, st_r[NSTEP].mh} >= {den, 7'd0});
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== src/opu_step.sv =====
// Adam step: pipelined quotient of corrected moments, rate scaling, final select.
module opu_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [23:0]               lr,
  input  logic                      in_valid,
  input  opu_pkg::sq_t              in_data,
  output logic                      out_valid,
  output logic [opu_pkg::IDX_W-1:0] out_idx,
  output logic [31:0]               out_val
);

  localparam int NSTEP = 31;

  typedef struct packed {
    opu_pkg::side_t side;
    logic [40:0]    rem;
    logic [30:0]    w;
    logic [40:0]    den;
    logic           ovf2;
  } qstg_t;

  function automatic qstg_t div_step(input qstg_t s);
    qstg_t       o;
    logic [41:0] t;
    o = s;
    t = {s.rem, s.w[30]};
    if (t >= {1'b0, s.den}) begin
      o.rem = 41'(t - {1'b0, s.den});
      o.w   = {s.w[29:0], 1'b1};
    end else begin
      o.rem = t[40:0];
      o.w   = {s.w[29:0], 1'b0};
    end
    return o;
  endfunction

  qstg_t            init_c;
  qstg_t            st_r [1:NSTEP];
  logic [NSTEP+1:1] vld_r;
  logic [30:0]      q;
  logic [54:0]      prod_r;
  opu_pkg::side_t   side_r;
  logic [39:0]      x_x, step_x;
  logic [31:0]      r_adam;
  logic [opu_pkg::IDX_W-1:0] idx_r;
  logic [31:0]      val_r;
  logic             out_v_r;

  assign init_c.side = in_data.side;
  assign init_c.rem  = {17'd0, in_data.mh[30:7]};
  assign init_c.w    = {in_data.mh[6:0], 24'd0};
  assign init_c.den  = in_data.den;
  assign init_c.ovf2 = in_data.ovf2;

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    qstg_t src;
    if (k == 1) begin : g_first
      assign src = init_c;
    end else begin : g_next
      assign src = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) st_r[k] <= div_step(src);
    end
  end

  assign q = st_r[NSTEP].ovf2 ? 31'h7FFF_FFFF : st_r[NSTEP].w;

  assign x_x    = {{8{side_r.val[31]}}, side_r.val};
  assign step_x = {9'd0, prod_r[54:24]};
  assign r_adam = side_r.neg ? opu_pkg::sat32(x_x + step_x) : opu_pkg::sat32(x_x - step_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[NSTEP:1], in_valid};
      out_v_r <= vld_r[NSTEP+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= q * lr;
      side_r <= st_r[NSTEP].side;
      idx_r  <= side_r.idx;
      val_r  <= (side_r.mode == opu_pkg::MODE_ADAM) ? r_adam : side_r.val;
    end
  end

  assign out_valid = out_v_r;
  assign out_idx   = idx_r;
  assign out_val   = val_r;

endmodule

// ===== src/optimizer_parameter_update.sv =====
// Top level of the optimizer parameter update block (plain descent, momentum, adam).
//
// Input channel (in_*): one transfer carries one trainable parameter: its index,
// its current Q8.24 value and its Q8.24 gradient; in_tlast marks the last
// parameter of one update call, which advances the adam time step.
// Output channel (out_*): one transfer per input, in order: the index echoed and
// the updated, saturated Q8.24 value.
// Config channel (cfg_*): register index and data; always ready. Write only while
// no transfer is in flight.
// Every rule takes the same path from input transfer to out_tvalid; the long tail
// of that path is the chain of bit-per-stage dividers and the square root.
// Throughput: one transfer per cycle unless the pipeline holds. In momentum and adam
// mode a parameter whose index is still in its moment read-modify-write window
// (three stages behind the store read) holds in_tready low until that window clears.
// Reset: registers take their reset values, beta powers return to one, and the
// two 4096-entry moment stores are swept to zero, one entry a cycle; in_tready
// stays low until the sweep is done.
// Stall: a two-entry output buffer keeps taking results while out_tready is low;
// once both are full the whole pipeline holds, nothing is dropped or repeated.
module optimizer_parameter_update (
  input  logic        clk,
  input  logic        rst_n,
  // fields from bit 0: param_index[11:0], value_in[43:12], gradient[75:44], zero pad
  input  logic [79:0] in_tdata,
  input  logic        in_tlast,   // end_of_call
  input  logic        in_tvalid,
  output logic        in_tready,
  // fields from bit 0: param_index_out[11:0], value_out[43:12], zero pad
  output logic [47:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  opu_pkg::cfg_t cfg_r;

  logic          en, acc, in_ok;
  logic          st_v, nr_v, sq_v, fin_v;
  opu_pkg::mom_t st_d;
  opu_pkg::nrm_t nr_d;
  opu_pkg::sq_t  sq_d;
  logic [opu_pkg::IDX_W-1:0] fin_idx;
  logic [31:0]   fin_val;

  logic [43:0]   out_r, skid_r;
  logic          out_v_r, skid_v_r;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= opu_pkg::MODE_SGD;
      cfg_r.lr       <= 24'd167772;
      cfg_r.mom_beta <= 24'd15099494;
      cfg_r.beta1    <= 24'd15099494;
      cfg_r.beta2    <= 24'd16760439;
    end else if (cfg_valid) begin
      unique case (opu_pkg::reg_idx_t'(cfg_index))
        opu_pkg::REG_MODE:     cfg_r.mode     <= opu_pkg::mode_t'(cfg_data[1:0]);
        opu_pkg::REG_LR:       cfg_r.lr       <= cfg_data;
        opu_pkg::REG_MOM_BETA: cfg_r.mom_beta <= cfg_data;
        opu_pkg::REG_BETA1:    cfg_r.beta1    <= cfg_data;
        opu_pkg::REG_BETA2:    cfg_r.beta2    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless the skid entry is occupied
  assign en        = !skid_v_r;
  assign in_tready = en && in_ok;
  assign acc       = in_tvalid && in_tready;

  opu_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .acc       (acc),
    .cfg       (cfg_r),
    .in_idx    (in_tdata[11:0]),
    .in_x      (in_tdata[43:12]),
    .in_g      (in_tdata[75:44]),
    .in_last   (in_tlast),
    .in_ok     (in_ok),
    .out_valid (st_v),
    .out_data  (st_d)
  );

  opu_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (st_v),
    .in_data   (st_d),
    .out_valid (nr_v),
    .out_data  (nr_d)
  );

  opu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nr_v),
    .in_data   (nr_d),
    .out_valid (sq_v),
    .out_data  (sq_d)
  );

  opu_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .lr        (cfg_r.lr),
    .in_valid  (sq_v),
    .in_data   (sq_d),
    .out_valid (fin_v),
    .out_idx   (fin_idx),
    .out_val   (fin_val)
  );

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      out_v_r  <= skid_v_r || (en && fin_v);
      skid_v_r <= 1'b0;
    end else if (en && fin_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      if (skid_v_r) out_r <= skid_r;
      else if (en && fin_v) out_r <= {fin_val, fin_idx};
    end else if (en && fin_v) begin
      skid_r <= {fin_val, fin_idx};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_r};

endmodule

// ===== tb/sv/optimizer_parameter_update_test.sv =====
// Self-checking testbench for the optimizer parameter update block.
module optimizer_parameter_update_test;

  localparam int WATCHDOG_LIMIT = 20000;  // covers the store sweep of all 4096 entries
  localparam int DRAIN_CYCLES   = 140;    // outlasts the block latency
  localparam longint ONE        = 64'd16777216;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  // fields from bit 0: param_index[11:0], value_in[43:12], gradient[75:44], zero pad
  logic [79:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // fields from bit 0: param_index_out[11:0], value_out[43:12], zero pad
  logic [47:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  optimizer_parameter_update i_dut (.*);

  initial forever #4 clk = ~clk;

  // Shadow of the block: registers, moment stores, beta powers
  opu_pkg::mode_t rule;
  logic [23:0] rate, mom_beta, beta1, beta2;
  logic [31:0] moment1 [opu_pkg::PARAM_COUNT];
  logic [31:0] moment2 [opu_pkg::PARAM_COUNT];
  logic [63:0] beta1_pow, beta2_pow;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] value;
  } update_t;
  update_t pending_updates[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm_in = 1'b0;   // stretches with no input gaps
  bit  calm_out = 1'b0;  // stretches with no output stalls
  int  stall_left = 0;

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor(a * b / 2^24); arithmetic shift floors negatives
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] adam_value(int i, longint x, longint g, bit last);
    longint      m;
    logic [63:0] ag, g2, v, p1, p2, c1, c2, am, mh, vh, s, q, step;
    m = clamp32(qmul(sx32(moment1[i]), beta1) + qmul(g, ONE - beta1));
    ag = (g < 0) ? -g : g;
    g2 = (ag * ag) >> 24;
    v = ((64'(moment2[i]) * beta2) >> 24) + ((g2 * (ONE - beta2)) >> 24);
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    moment1[i] = m[31:0];
    moment2[i] = v[31:0];
    p1 = (beta1_pow * beta1) >> 24;
    p2 = (beta2_pow * beta2) >> 24;
    c1 = ONE - p1;
    c2 = ONE - p2;
    if (c1 == 0) c1 = 1;
    if (c2 == 0) c2 = 1;
    am = (m < 0) ? -m : m;
    mh = (am << 24) / c1;
    if (mh > 64'h7FFF_FFFF) mh = 64'h7FFF_FFFF;
    vh = (v << 24) / c2;
    if (vh < (64'd1 << 40)) s = int_sqrt(vh << 24);
    else s = int_sqrt(vh << 8) << 8;
    q = (mh << 24) / (s + 1);
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    step = (q * rate) >> 24;
    if (last) begin
      beta1_pow = p1;
      beta2_pow = p2;
    end
    return 32'(clamp32((m < 0) ? x + longint'(step) : x - longint'(step)));
  endfunction

  // Expected updated value for one accepted parameter; advances the shadow state
  function automatic logic [31:0] updated_value(logic [11:0] idx, logic [31:0] xv,
                                                logic [31:0] gv, bit last);
    int     i;
    longint x, g, vel;
    i = idx % opu_pkg::PARAM_COUNT;
    x = sx32(xv);
    g = sx32(gv);
    case (rule)
      opu_pkg::MODE_SGD: begin
        return 32'(clamp32(x - qmul(g, rate)));
      end
      opu_pkg::MODE_MOM: begin
        vel = clamp32(qmul(sx32(moment1[i]), mom_beta) + g);
        moment1[i] = vel[31:0];
        return 32'(clamp32(x - qmul(vel, rate)));
      end
      opu_pkg::MODE_ADAM: begin
        return adam_value(i, x, g, last);
      end
      default: begin
        return xv;  // unused rule passes the value through
      end
    endcase
  endfunction

  task automatic send_param(logic [11:0] idx, logic [31:0] xv, logic [31:0] gv, bit last);
    int gap;
    update_t u;
    gap = calm_in ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, gv, xv, idx};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    u.idx = idx;
    u.value = updated_value(idx, xv, gv, last);
    pending_updates = {pending_updates, u};
  endtask

  // Waits for every result, then lets the pipeline empty before a register write
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(opu_pkg::reg_idx_t r, logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (r)
      opu_pkg::REG_MODE:     rule = opu_pkg::mode_t'(d[1:0]);
      opu_pkg::REG_LR:       rate = d;
      opu_pkg::REG_MOM_BETA: mom_beta = d;
      opu_pkg::REG_BETA1:    beta1 = d;
      opu_pkg::REG_BETA2:    beta2 = d;
      default: ;
    endcase
  endtask

  task automatic test_plain_descent();
    // reset settings first, then the rate extremes against value/gradient extremes
    send_param(12'd0, 32'h0100_0000, 32'h0100_0000, 1'b0);
    drain();
    write_reg(opu_pkg::REG_LR, 24'hFF_FFFF);
    send_param(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_param(12'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_param(12'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    drain();
    write_reg(opu_pkg::REG_LR, 24'd0);
    send_param(12'd3, 32'h1234_5678, 32'h7FFF_FFFF, 1'b0);
    drain();
  endtask

  task automatic test_momentum();
    write_reg(opu_pkg::REG_MODE, 24'(opu_pkg::MODE_MOM));
    write_reg(opu_pkg::REG_LR, 24'h80_0000);
    write_reg(opu_pkg::REG_MOM_BETA, 24'hFF_FFFF);
    // same index back to back: velocity read-modify-write hazard
    repeat (3) send_param(12'd5, 32'h0, 32'h7FFF_FFFF, 1'b0);
    send_param(12'd5, 32'h8000_0000, 32'h8000_0000, 1'b1);
    drain();
    write_reg(opu_pkg::REG_MOM_BETA, 24'd0);
    send_param(12'd5, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    drain();
  endtask

  task automatic test_adam();
    write_reg(opu_pkg::REG_MODE, 24'(opu_pkg::MODE_ADAM));
    write_reg(opu_pkg::REG_BETA1, 24'hFF_FFFF);  // correction near zero
    write_reg(opu_pkg::REG_BETA2, 24'hFF_FFFF);
    send_param(12'd7, 32'h0100_0000, 32'h7FFF_FFFF, 1'b1);
    send_param(12'd7, 32'h0100_0000, 32'h8000_0000, 1'b1);
    drain();
    write_reg(opu_pkg::REG_BETA1, 24'd0);
    write_reg(opu_pkg::REG_BETA2, 24'd0);
    send_param(12'd7, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_param(12'd8, 32'h8000_0000, 32'h0, 1'b1);
    drain();
    // moments left over from momentum mode are shared
    write_reg(opu_pkg::REG_BETA1, 24'd15099494);
    write_reg(opu_pkg::REG_BETA2, 24'd16760439);
    send_param(12'd5, 32'h0, 32'h0001_0000, 1'b1);
    drain();
  endtask

  task automatic test_unused_mode();
    write_reg(opu_pkg::REG_MODE, 24'(opu_pkg::MODE_NONE));
    send_param(12'd5, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 1'b1);
    send_param(12'hABC, 32'h8000_0000, 32'h8000_0000, 1'b0);
    drain();
  endtask

  function automatic logic [31:0] rand_q24();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      3: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] rand_frac();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'(24'hFF_FFFF - $urandom_range(0, 24'h0F_FFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_random();
    int   n;
    logic [11:0] idx;
    for (int phase = 0; phase < 12; phase++) begin
      // mostly the real rules, now and then the unused one
      write_reg(opu_pkg::REG_MODE, 24'((phase % 6 == 5) ? opu_pkg::MODE_NONE :
                                       opu_pkg::mode_t'(phase % 3)));
      write_reg(opu_pkg::REG_LR, rand_frac());
      write_reg(opu_pkg::REG_MOM_BETA, rand_frac());
      write_reg(opu_pkg::REG_BETA1, rand_frac());
      write_reg(opu_pkg::REG_BETA2, rand_frac());
      n = $urandom_range(80, 120);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 31) == 0) calm_in = ~calm_in;
        // a small pool of indexes keeps moment hazards frequent
        idx = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 7)) : 12'($urandom);
        send_param(idx, rand_q24(), rand_q24(), $urandom_range(0, 15) == 0);
      end
      drain();
    end
  endtask

  // Result side: backpressure, in-order compare, watchdog
  always @(posedge clk) begin
    update_t exp_u;
    if (in_tvalid && in_tready || out_tvalid && out_tready || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (out_tvalid && out_tready) begin
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", out_tdata);
      end else begin
        exp_u = pending_updates.pop_front();
        if (out_tdata[11:0] !== exp_u.idx || out_tdata[43:12] !== exp_u.value ||
            out_tdata[47:44] !== 4'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected idx %h value %h, got idx %h value %h",
                     exp_u.idx, exp_u.value, out_tdata[11:0], out_tdata[43:12]);
        end
      end
      if ($urandom_range(0, 63) == 0) calm_out = ~calm_out;
      stall_left = calm_out ? 0 : $urandom_range(0, 10);
      out_tready <= (stall_left == 0);
    end else if (!out_tready) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) out_tready <= 1'b1;
    end
  end

  initial begin
    rule = opu_pkg::MODE_SGD;
    rate = 24'd167772;
    mom_beta = 24'd15099494;
    beta1 = 24'd15099494;
    beta2 = 24'd16760439;
    beta1_pow = ONE;
    beta2_pow = ONE;
    foreach (moment1[i]) begin
      moment1[i] = '0;
      moment2[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_descent();
    test_momentum();
    test_adam();
    test_unused_mode();
    test_random();
    drain();
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
